/* rtl/wif_pkg.sv */
package wif_pkg;

	localparam int MAX_KERNEL_DEF = 5;
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int ADDR_W         = 6;
	localparam int DATA_W         = 64;

	localparam logic [2:0] REG_MODE    = 3'd0;
	localparam logic [2:0] REG_RADIUS  = 3'd1;
	localparam logic [2:0] REG_AMOUNT  = 3'd2;
	localparam logic [2:0] REG_WNEAR   = 3'd3;
	localparam logic [2:0] REG_WFAR    = 3'd4;
	localparam logic [2:0] REG_WIDTH   = 3'd5;
	localparam logic [2:0] REG_HEIGHT  = 3'd6;

	localparam logic [1:0] MODE_BOX     = 2'd0;
	localparam logic [1:0] MODE_GAUSS   = 2'd1;
	localparam logic [1:0] MODE_UNSHARP = 2'd2;

	typedef struct packed {
		logic [1:0]         filter_mode;
		logic [1:0]         kernel_radius;
		logic signed [11:0] unsharp_amount;
		logic [47:0]        weights_near;
		logic [47:0]        weights_far;
		logic [10:0]        image_width;
		logic [12:0]        image_height;
	} cfg_t;

endpackage

/* rtl/wif_ram.sv */
module wif_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/wif_cfg.sv */
module wif_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [wif_pkg::ADDR_W-1:0]  paddr,
	input  logic [wif_pkg::DATA_W-1:0]  pwdata,
	output logic [wif_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output wif_pkg::cfg_t               cfg
);

	wif_pkg::cfg_t cfg_q;
	logic          wr;
	logic [2:0]    idx;

	assign wr     = psel && penable && pwrite;
	assign idx    = paddr[5:3];
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.filter_mode    <= wif_pkg::MODE_BOX;
			cfg_q.kernel_radius  <= 2'd1;
			cfg_q.unsharp_amount <= 12'sd256;
			cfg_q.weights_near   <= '0;
			cfg_q.weights_far    <= '0;
			cfg_q.image_width    <= 11'd640;
			cfg_q.image_height   <= 13'd480;
		end else if (wr) begin
			case (idx)
				wif_pkg::REG_MODE:   cfg_q.filter_mode    <= pwdata[1:0];
				wif_pkg::REG_RADIUS: cfg_q.kernel_radius  <= pwdata[1:0];
				wif_pkg::REG_AMOUNT: cfg_q.unsharp_amount <= $signed(pwdata[11:0]);
				wif_pkg::REG_WNEAR:  cfg_q.weights_near   <= pwdata[47:0];
				wif_pkg::REG_WFAR:   cfg_q.weights_far    <= pwdata[47:0];
				wif_pkg::REG_WIDTH:  cfg_q.image_width    <= pwdata[10:0];
				wif_pkg::REG_HEIGHT: cfg_q.image_height   <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			wif_pkg::REG_MODE:   prdata = 64'(cfg_q.filter_mode);
			wif_pkg::REG_RADIUS: prdata = 64'(cfg_q.kernel_radius);
			wif_pkg::REG_AMOUNT: prdata = 64'($unsigned(cfg_q.unsharp_amount));
			wif_pkg::REG_WNEAR:  prdata = 64'(cfg_q.weights_near);
			wif_pkg::REG_WFAR:   prdata = 64'(cfg_q.weights_far);
			wif_pkg::REG_WIDTH:  prdata = 64'(cfg_q.image_width);
			wif_pkg::REG_HEIGHT: prdata = 64'(cfg_q.image_height);
			default:             prdata = '0;
		endcase
	end

endmodule

/* rtl/wif_core.sv */
module wif_core #(
	parameter int MAX_KERNEL = wif_pkg::MAX_KERNEL_DEF,
	parameter int MAX_WIDTH  = wif_pkg::MAX_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  wif_pkg::cfg_t cfg,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [7:0]    pixel_value,
	input  logic          is_filler,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [7:0]    filtered_pixel,
	output logic          frame_last
);

	localparam int RING       = MAX_KERNEL + 1;
	localparam int MAX_RADIUS = (MAX_KERNEL - 1) / 2;
	localparam int RDW        = (MAX_RADIUS > 0) ? $clog2(MAX_RADIUS + 1) : 1;
	localparam int CW         = $clog2(MAX_WIDTH);
	localparam int WW         = $clog2(MAX_WIDTH + 1);
	localparam int XW         = WW + 2;
	localparam int RW         = 13;
	localparam int RGW        = $clog2(RING);
	localparam int DEPTH      = RING * MAX_WIDTH;
	localparam int AW         = $clog2(DEPTH);
	localparam int DLW        = RDW + WW + 1;
	localparam int SW         = $clog2(MAX_KERNEL * MAX_KERNEL * 255 + 1);
	localparam int GW         = SW + 16;
	localparam int RS         = SW + $clog2(MAX_KERNEL * MAX_KERNEL) + 1;
	localparam int MRW        = RS + 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_LAST = 3'd2;
	localparam logic [2:0] ST_F1   = 3'd3;
	localparam logic [2:0] ST_F2   = 3'd4;
	localparam logic [2:0] ST_F3   = 3'd5;

	// reciprocal of the window area per radius
	logic [MRW-1:0] recip [MAX_RADIUS+1];
	for (genvar g = 0; g <= MAX_RADIUS; g++) begin : g_recip
		localparam longint AREA = (2 * g + 1) * (2 * g + 1);
		localparam longint RV   = ((64'd1 << RS) + AREA - 1) / AREA;
		assign recip[g] = MRW'(RV);
	end

	logic [2:0]            state_q;
	logic                  active_q;
	logic [WW-1:0]         lat_w_q;
	logic [RW-1:0]         lat_h_q;
	logic [RDW-1:0]        lat_r_q;
	logic [DLW-1:0]        delay_q, cnt_q;
	logic [CW-1:0]         in_col_q, out_col_q;
	logic [RW-1:0]         in_row_q, out_row_q;
	logic [RGW-1:0]        in_ring_q, out_ring_q;
	logic signed [RDW:0]   dy_q, dx_q;
	logic [SW-1:0]         sum_q;
	logic [GW-1:0]         gacc_q;
	logic [7:0]            orig_q, blur_q, box_q;
	logic [SW+MRW-1:0]     boxp_q;
	logic signed [23:0]    v_q;
	logic                  rd_s1, inb_s1, ctr_s1;
	logic [15:0]           w_s1;
	logic                  out_valid_q, out_last_q;
	logic [7:0]            out_pix_q;

	logic [WW-1:0]         sat_w, cur_w;
	logic [RW-1:0]         sat_h, cur_h;
	logic [RDW-1:0]        sat_r, cur_r;
	logic [DLW-1:0]        cur_delay;
	logic                  acc, wr_en, out_free, load, last;
	logic [7:0]            pix, rdata, p, res;
	logic [AW-1:0]         waddr, raddr;
	logic signed [RW+1:0]  rr;
	logic signed [XW-1:0]  cc;
	logic signed [RGW+1:0] rt;
	logic [RGW-1:0]        ring_idx;
	logic                  inb;
	logic signed [RDW:0]   rlim;
	logic [RDW:0]          ady, adx;
	logic [7:0]            dsq;
	logic [15:0]           wsel;
	logic [GW-1:0]         gsh;
	logic signed [8:0]     diff;
	logic signed [20:0]    prod;

	always_comb begin
		if (cfg.image_width == '0) begin
			sat_w = WW'(1);
		end else if (32'(cfg.image_width) > MAX_WIDTH) begin
			sat_w = WW'(MAX_WIDTH);
		end else begin
			sat_w = WW'(cfg.image_width);
		end
		sat_h = (cfg.image_height == '0) ? RW'(1) : cfg.image_height;
		sat_r = (32'(cfg.kernel_radius) > MAX_RADIUS) ? RDW'(MAX_RADIUS)
			: RDW'(cfg.kernel_radius);
		cur_w = active_q ? lat_w_q : sat_w;
		cur_h = active_q ? lat_h_q : sat_h;
		cur_r = active_q ? lat_r_q : sat_r;
		cur_delay = active_q ? delay_q
			: DLW'(DLW'(sat_r) * DLW'(sat_w) + DLW'(sat_r));
	end

	assign in_stall = (state_q != ST_IDLE);
	assign acc      = in_valid && (state_q == ST_IDLE);
	assign pix      = is_filler ? 8'd0 : pixel_value;
	assign wr_en    = acc && (in_row_q < cur_h);
	assign waddr    = AW'(AW'(in_ring_q) * AW'(MAX_WIDTH) + AW'(in_col_q));

	assign rlim = $signed({1'b0, lat_r_q});
	always_comb begin
		rr  = $signed({2'b00, out_row_q}) + (RW+2)'(dy_q);
		cc  = $signed({2'b00, WW'(out_col_q)}) + XW'(dx_q);
		rt  = $signed({2'b00, out_ring_q}) + (RGW+2)'(dy_q);
		if (rt < 0) begin
			ring_idx = RGW'(rt + (RGW+2)'(RING));
		end else if (rt >= (RGW+2)'(RING)) begin
			ring_idx = RGW'(rt - (RGW+2)'(RING));
		end else begin
			ring_idx = RGW'(rt);
		end
		inb = (rr >= 0) && (rr < $signed({2'b00, lat_h_q}))
			&& (cc >= 0) && (cc < $signed({2'b00, lat_w_q}));
		raddr = AW'(AW'(ring_idx) * AW'(MAX_WIDTH) + AW'(cc[CW-1:0]));
		ady = (dy_q < 0) ? $unsigned(-dy_q) : $unsigned(dy_q);
		adx = (dx_q < 0) ? $unsigned(-dx_q) : $unsigned(dx_q);
		dsq = 8'(8'(ady) * 8'(ady) + 8'(adx) * 8'(adx));
		case (dsq)
			8'd0:    wsel = cfg.weights_near[15:0];
			8'd1:    wsel = cfg.weights_near[31:16];
			8'd2:    wsel = cfg.weights_near[47:32];
			8'd4:    wsel = cfg.weights_far[15:0];
			8'd5:    wsel = cfg.weights_far[31:16];
			8'd8:    wsel = cfg.weights_far[47:32];
			default: wsel = 16'd0;
		endcase
	end

	wif_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (waddr),
		.wdata (pix),
		.re    (state_q == ST_RD),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign p    = inb_s1 ? rdata : 8'd0;
	assign gsh  = gacc_q >> 16;
	assign diff = $signed({1'b0, orig_q}) - $signed({1'b0, blur_q});
	assign prod = diff * cfg.unsharp_amount;

	always_comb begin
		case (cfg.filter_mode)
			wif_pkg::MODE_GAUSS: res = blur_q;
			wif_pkg::MODE_UNSHARP: begin
				if (v_q >= 24'sd65280) begin
					res = 8'd255;
				end else if (v_q <= 24'sd0) begin
					res = 8'd0;
				end else begin
					res = v_q[15:8];
				end
			end
			default: res = box_q;
		endcase
	end

	assign out_free = !out_valid_q || !out_stall;
	assign load     = (state_q == ST_F3) && out_free;
	assign last     = (32'(out_row_q) + 1 >= 32'(lat_h_q))
		&& (32'(out_col_q) + 1 >= 32'(lat_w_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			active_q    <= 1'b0;
			lat_w_q     <= '0;
			lat_h_q     <= '0;
			lat_r_q     <= '0;
			delay_q     <= '0;
			cnt_q       <= '0;
			in_col_q    <= '0;
			in_row_q    <= '0;
			in_ring_q   <= '0;
			out_col_q   <= '0;
			out_row_q   <= '0;
			out_ring_q  <= '0;
			dy_q        <= '0;
			dx_q        <= '0;
			rd_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_s1 <= (state_q == ST_RD);
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						if (!active_q) begin
							active_q <= 1'b1;
							lat_w_q  <= sat_w;
							lat_h_q  <= sat_h;
							lat_r_q  <= sat_r;
							delay_q  <= cur_delay;
						end
						if (wr_en) begin
							if (32'(in_col_q) + 1 >= 32'(cur_w)) begin
								in_col_q  <= '0;
								in_row_q  <= in_row_q + 1'b1;
								in_ring_q <= (32'(in_ring_q) == RING - 1) ? '0
									: in_ring_q + 1'b1;
							end else begin
								in_col_q <= in_col_q + 1'b1;
							end
						end
						if (cnt_q >= cur_delay) begin
							state_q <= ST_RD;
							dy_q    <= -$signed({1'b0, cur_r});
							dx_q    <= -$signed({1'b0, cur_r});
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				ST_RD: begin
					if (dx_q == rlim) begin
						dx_q <= -rlim;
						if (dy_q == rlim) begin
							state_q <= ST_LAST;
						end else begin
							dy_q <= dy_q + 1'b1;
						end
					end else begin
						dx_q <= dx_q + 1'b1;
					end
				end
				ST_LAST: state_q <= ST_F1;
				ST_F1:   state_q <= ST_F2;
				ST_F2:   state_q <= ST_F3;
				ST_F3: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (last) begin
							active_q   <= 1'b0;
							cnt_q      <= '0;
							in_col_q   <= '0;
							in_row_q   <= '0;
							in_ring_q  <= '0;
							out_col_q  <= '0;
							out_row_q  <= '0;
							out_ring_q <= '0;
						end else if (32'(out_col_q) + 1 >= 32'(lat_w_q)) begin
							out_col_q  <= '0;
							out_row_q  <= out_row_q + 1'b1;
							out_ring_q <= (32'(out_ring_q) == RING - 1) ? '0
								: out_ring_q + 1'b1;
						end else begin
							out_col_q <= out_col_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		inb_s1 <= inb;
		w_s1   <= wsel;
		ctr_s1 <= (dy_q == 0) && (dx_q == 0);
		if (acc) begin
			sum_q  <= '0;
			gacc_q <= '0;
		end else if (rd_s1) begin
			sum_q  <= sum_q + SW'(p);
			gacc_q <= gacc_q + GW'(24'(p) * 24'(w_s1));
			if (ctr_s1) begin
				orig_q <= p;
			end
		end
		if (state_q == ST_F1) begin
			blur_q <= (gsh > GW'(255)) ? 8'd255 : gsh[7:0];
			boxp_q <= (SW+MRW)'(sum_q) * (SW+MRW)'(recip[lat_r_q]);
		end
		if (state_q == ST_F2) begin
			box_q <= 8'(boxp_q >> RS);
			v_q   <= 24'($signed({1'b0, orig_q, 8'd0})) + 24'(prod);
		end
		if (load) begin
			out_pix_q  <= res;
			out_last_q <= last;
		end
	end

	assign out_valid      = out_valid_q;
	assign filtered_pixel = out_pix_q;
	assign frame_last     = out_last_q;

	a_rd_active: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD) |-> active_q)
		else $error("window read outside a frame");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !(out_valid_q && out_stall))
		else $error("output word overwritten while stalled");
	a_last_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LAST) |-> rd_s1)
		else $error("final window read missing");
	a_win_rng: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD) |-> (dx_q <= rlim && dy_q <= rlim))
		else $error("window offset out of range");

endmodule

/* rtl/window_image_filter_top.sv */
// 2D window filter over 8-bit grayscale frames in raster order.
// Input channel: in_valid/in_stall with pixel_value and is_filler. Fillers
// after the last pixel of a frame push the remaining centres out; a filler
// inside the frame counts as a zero pixel.
// Output channel: out_valid/out_stall with filtered_pixel and frame_last,
// one word per window centre, raster order, frame_last on the final one.
// Frame geometry (width, height, radius) is latched at the first item of a
// frame; mode, gain and weights are live. Registers sit on an APB port.
// Pacing: an item that yields no word leaves the block ready for the next;
// an item that yields a word holds input until that word is loaded, while
// the single read port of the line store walks the window one pixel per
// cycle. The first word comes out after R*W+R+1 items of the frame.
// The sums then pass ST_LAST, ST_F1 and ST_F2; ST_F3 loads the word.
// A finished word waits in the output register while the next item is taken;
// if it is still stalled when the next word is ready, the block holds input.
// Reset clears counters, registers to their defaults and the output valid;
// the line store needs no clear, every entry read is written first.
module window_image_filter_top #(
	parameter int MAX_KERNEL = wif_pkg::MAX_KERNEL_DEF,
	parameter int MAX_WIDTH  = wif_pkg::MAX_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [wif_pkg::ADDR_W-1:0] paddr,
	input  logic [wif_pkg::DATA_W-1:0] pwdata,
	output logic [wif_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [7:0]                 pixel_value,
	input  logic                       is_filler,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [7:0]                 filtered_pixel,
	output logic                       frame_last
);

	wif_pkg::cfg_t cfg;

	wif_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	wif_core #(.MAX_KERNEL(MAX_KERNEL), .MAX_WIDTH(MAX_WIDTH)) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.pixel_value    (pixel_value),
		.is_filler      (is_filler),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.filtered_pixel (filtered_pixel),
		.frame_last     (frame_last)
	);

endmodule
